// ----- src/mh3_pkg.sv -----
// shared types and constants for the word-serial hash engine
package mh3_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned CountW = 3;

  localparam logic [WordW-1:0] MixMul1 = 32'h0acf_fe3d;
  localparam logic [WordW-1:0] MixMul2 = 32'h0e4e_f5f3;
  localparam logic [WordW-1:0] FinMul = 32'ha729_a897;
  localparam int unsigned MixRot = 11;
  localparam int unsigned FinShift = 18;
  localparam logic [WordW-1:0] SeedReset = 32'd67295;

  localparam logic [CountW-1:0] CountFull = 3'd4;
  localparam logic [CountW-1:0] CountOne = 3'd1;
  localparam logic [CountW-1:0] CountTwo = 3'd2;
  localparam logic [CountW-1:0] CountThree = 3'd3;
  localparam logic [CountW-1:0] CountNone = 3'd0;

  localparam int unsigned QueueDepthDefault = 2;

  // classified request handed from front to back
  typedef struct packed {
    logic [WordW-1:0] data;       // key bytes, unused bytes cleared
    logic             fold;       // at least one byte present
    logic             full;       // four or more bytes: data replaces k
    logic             first;
    logic             last;
    logic [WordW-1:0] key_length;
  } item_t;

endpackage

// ----- src/mh3_front.sv -----
// front end: classifies an incoming request by byte count and masks unused bytes
module mh3_front (
  input  logic [mh3_pkg::WordW-1:0]  key_word_i,
  input  logic [mh3_pkg::CountW-1:0] byte_count_i,
  input  logic                       first_word_i,
  input  logic                       last_word_i,
  input  logic [mh3_pkg::WordW-1:0]  key_length_i,
  output mh3_pkg::item_t             item_o
);

  logic [mh3_pkg::WordW-1:0] data;
  logic                      full;
  logic                      fold;

  // byte mask; counts above four count as a full word
  always_comb begin
    full = 1'b0;
    fold = 1'b1;
    data = key_word_i;
    unique case (byte_count_i)
      mh3_pkg::CountNone: begin
        fold = 1'b0;
        data = '0;
      end
      mh3_pkg::CountOne: begin
        data = {24'h0, key_word_i[7:0]};
      end
      mh3_pkg::CountTwo: begin
        data = {16'h0, key_word_i[15:0]};
      end
      mh3_pkg::CountThree: begin
        data = {8'h0, key_word_i[23:0]};
      end
      default: begin
        full = 1'b1;
      end
    endcase
  end

  assign item_o.data       = data;
  assign item_o.fold       = fold;
  assign item_o.full       = full;
  assign item_o.first      = first_word_i;
  assign item_o.last       = last_word_i;
  assign item_o.key_length = key_length_i;

endmodule

// ----- src/mh3_queue.sv -----
// short request queue between front and back
module mh3_queue #(
  parameter int unsigned Depth = mh3_pkg::QueueDepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mh3_pkg::item_t push_item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output mh3_pkg::item_t pop_item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  mh3_pkg::item_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign full_o     = (cnt_q == CntFull);
  assign valid_o    = (cnt_q != '0);
  assign pop_item_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ----- src/mh3_back.sv -----
// back end: mixing sequencer around one shared multiplier, plus output register
module mh3_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [mh3_pkg::WordW-1:0] seed_i,
  input  logic                      item_valid_i,
  input  mh3_pkg::item_t            item_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [mh3_pkg::WordW-1:0] hash_value_o
);

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StMul2 = 5'b00010,
    StFold = 5'b00100,
    StFin1 = 5'b01000,
    StFin2 = 5'b10000
  } state_e;

  state_e                    state_q, state_d;
  logic [mh3_pkg::WordW-1:0] h_q, h_d;
  logic [mh3_pkg::WordW-1:0] k_q, k_d;
  logic [mh3_pkg::WordW-1:0] p_q, p_d;
  logic                      last_q, last_d;
  logic                      out_valid_q, out_valid_d;
  logic [mh3_pkg::WordW-1:0] out_q, out_d;

  logic [mh3_pkg::WordW-1:0] h_base;
  logic [mh3_pkg::WordW-1:0] k_base;
  logic [mh3_pkg::WordW-1:0] k_in;
  logic [mh3_pkg::WordW-1:0] p_rot;
  logic [mh3_pkg::WordW-1:0] h_pre;
  logic [mh3_pkg::WordW-1:0] mul_a;
  logic [mh3_pkg::WordW-1:0] mul_b;
  logic [mh3_pkg::WordW-1:0] mul_p;
  logic                      out_free;

  // state at the start of an item
  assign h_base = item_i.first ? (item_i.key_length + seed_i) : h_q;
  assign k_base = item_i.first ? '0 : k_q;
  assign k_in   = item_i.full ? item_i.data : (k_base ^ item_i.data);

  assign p_rot = {p_q[mh3_pkg::WordW-1-mh3_pkg::MixRot:0],
                  p_q[mh3_pkg::WordW-1 -: mh3_pkg::MixRot]};
  assign h_pre = h_q ^ (h_q >> mh3_pkg::FinShift);

  assign out_free = !out_valid_q || out_ready_i;

  // shared multiplier operand select
  always_comb begin
    mul_a = k_in;
    mul_b = mh3_pkg::MixMul1;
    unique case (state_q)
      StMul2: begin
        mul_a = p_rot;
        mul_b = mh3_pkg::MixMul2;
      end
      StFin1: begin
        mul_a = h_pre;
        mul_b = mh3_pkg::FinMul;
      end
      default: begin
        mul_a = k_in;
        mul_b = mh3_pkg::MixMul1;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // sequencer
  always_comb begin
    state_d     = state_q;
    h_d         = h_q;
    k_d         = k_q;
    p_d         = p_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    pop_o       = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (item_valid_i) begin
          pop_o  = 1'b1;
          h_d    = h_base;
          k_d    = k_base;
          last_d = item_i.last;
          if (item_i.fold) begin
            p_d     = mul_p;
            state_d = StMul2;
          end else if (item_i.last) begin
            state_d = StFin1;
          end
        end
      end
      StMul2: begin
        p_d     = mul_p;
        state_d = StFold;
      end
      StFold: begin
        k_d     = p_q;
        h_d     = (h_q + {h_q[mh3_pkg::WordW-2:0], 1'b0}) ^ p_q;
        state_d = last_q ? StFin1 : StIdle;
      end
      StFin1: begin
        p_d     = mul_p;
        state_d = StFin2;
      end
      StFin2: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = p_q ^ (p_q >> mh3_pkg::FinShift);
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      h_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      h_q         <= h_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    p_q   <= p_d;
    out_q <= out_d;
  end

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = out_q;

endmodule

// ----- src/murmur3_early_word_hash.sv -----
// top level of the word-serial hash engine
// Hashes a key streamed as 32-bit little-endian words with the early 32-bit
// MurmurHash3 mix. A word with bytes passes the back-end steps load and first
// multiply, second multiply and fold, a word with no bytes is only loaded, and
// the item marked last adds the finalization steps multiply and shift-xor
// before its result lands in the output register; one multiplier is shared by
// the multiply steps. The front end classifies requests into a short queue, so
// input flows while the back end works or the result waits, until the queue is
// full. The seed register takes a write in any cycle and is used on first words.
module murmur3_early_word_hash #(
  parameter int unsigned QueueDepth = mh3_pkg::QueueDepthDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [mh3_pkg::WordW-1:0]  key_word_i,
  input  logic [mh3_pkg::CountW-1:0] byte_count_i,
  input  logic                       first_word_i,
  input  logic                       last_word_i,
  input  logic [mh3_pkg::WordW-1:0]  key_length_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [mh3_pkg::WordW-1:0]  hash_value_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [mh3_pkg::WordW-1:0]  hash_seed_i
);

  logic [mh3_pkg::WordW-1:0] seed_q;
  mh3_pkg::item_t            front_item;
  mh3_pkg::item_t            back_item;
  logic                      q_full;
  logic                      q_valid;
  logic                      q_pop;

  // seed register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= mh3_pkg::SeedReset;
    end else if (cfg_valid_i) begin
      seed_q <= hash_seed_i;
    end
  end

  mh3_front u_front (
    .key_word_i  (key_word_i),
    .byte_count_i(byte_count_i),
    .first_word_i(first_word_i),
    .last_word_i (last_word_i),
    .key_length_i(key_length_i),
    .item_o      (front_item)
  );

  assign in_ready_o = !q_full;

  mh3_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_valid_i),
    .push_item_i(front_item),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_item_o (back_item)
  );

  mh3_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seed_i      (seed_q),
    .item_valid_i(q_valid),
    .item_i      (back_item),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .hash_value_o(hash_value_o)
  );

endmodule

// ----- src/mh3_checker.sv -----
// port-level checks for the hash engine, bound to the top level
module mh3_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       last_word_i,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [mh3_pkg::WordW-1:0]  hash_value_o,
  input logic                       cfg_valid_i,
  input logic                       cfg_ready_o
);

  logic [7:0] pending_q;
  logic       last_in;
  logic       res_out;

  assign last_in = in_valid_i && in_ready_o && last_word_i;
  assign res_out = out_valid_o && out_ready_i;

  // count of last requests taken whose result is not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (last_in && !res_out) begin
      pending_q <= pending_q + 1'b1;
    end else if (res_out && !last_in) begin
      pending_q <= pending_q - 1'b1;
    end
  end

  // a waiting result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hash_value_o))
    else $error("stalled result changed");

  // no result without a last request behind it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 8'd0)
    else $error("result without a last request");

  // seed writes never stall
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("seed write stalled");

  // output valid is low right after reset
  assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid out of reset");

endmodule

bind murmur3_early_word_hash mh3_checker u_mh3_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .last_word_i (last_word_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .hash_value_o(hash_value_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o)
);
